// ===== rtl/core/assert_macros.svh =====
// Shared assertion macros; expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define MVCB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("mvcb assertion failed");

`define MVCB_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("mvcb assertion failed");

`endif

// ===== rtl/core/mvcb_pkg.sv =====
package mvcb_pkg;
	localparam int ACC_W = 64;
	localparam int VOL_W = 48;
	localparam int DIV_BITS = $clog2(ACC_W);

	localparam logic [1:0] OP_VERTEX   = 2'd0;
	localparam logic [1:0] OP_TRIANGLE = 2'd1;
	localparam logic [1:0] OP_FINISH   = 2'd2;

	typedef struct packed {
		logic       vtx_upd;
		logic       tri_load;
		logic       cross_en;
		logic       dot_en;
		logic       wsum_en;
		logic       div_load;
		logic       div_step;
		logic       div_store;
		logic       emit;
		logic       ovf;
		logic [1:0] step;
	} cmd_t;

	typedef struct packed {
		logic vs_zero;
	} stat_t;
endpackage

// ===== rtl/core/mvcb_datapath.sv =====
module mvcb_datapath #(
	parameter int COORD_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mvcb_pkg::cmd_t                cmd,
	output mvcb_pkg::stat_t               stat,
	input  logic signed [COORD_BITS-1:0]  a_x,
	input  logic signed [COORD_BITS-1:0]  a_y,
	input  logic signed [COORD_BITS-1:0]  a_z,
	input  logic signed [COORD_BITS-1:0]  b_x,
	input  logic signed [COORD_BITS-1:0]  b_y,
	input  logic signed [COORD_BITS-1:0]  b_z,
	input  logic signed [COORD_BITS-1:0]  c_x,
	input  logic signed [COORD_BITS-1:0]  c_y,
	input  logic signed [COORD_BITS-1:0]  c_z,
	output logic signed [mvcb_pkg::VOL_W-1:0] six_volume,
	output logic signed [COORD_BITS-1:0]  centroid_x,
	output logic signed [COORD_BITS-1:0]  centroid_y,
	output logic signed [COORD_BITS-1:0]  centroid_z,
	output logic signed [COORD_BITS-1:0]  min_x,
	output logic signed [COORD_BITS-1:0]  min_y,
	output logic signed [COORD_BITS-1:0]  min_z,
	output logic signed [COORD_BITS-1:0]  max_x,
	output logic signed [COORD_BITS-1:0]  max_y,
	output logic signed [COORD_BITS-1:0]  max_z,
	output logic [COORD_BITS-1:0]         longest_extent,
	output logic                          result_valid
);
	import mvcb_pkg::*;

	localparam int CB  = COORD_BITS;
	localparam int CRW = 2 * CB + 1;
	localparam int DW  = 3 * CB + 3;
	localparam int SW  = CB + 2;
	localparam int PW  = DW + SW;
	localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
	localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
	localparam logic [ACC_W-1:0] LIM_POS = ACC_W'(CMAX);
	localparam logic [ACC_W-1:0] LIM_NEG = ACC_W'(CMAX) + ACC_W'(1);
	localparam logic signed [VOL_W-1:0] VMAX = {1'b0, {(VOL_W-1){1'b1}}};
	localparam logic signed [VOL_W-1:0] VMIN = {1'b1, {(VOL_W-1){1'b0}}};

	logic signed [CB-1:0] pin [3];
	logic signed [CB-1:0] a_q [3];
	logic signed [CB-1:0] b_q [3];
	logic signed [CB-1:0] c_q [3];
	logic signed [CRW-1:0] cr_q [3];
	logic signed [DW-1:0] d6_q;
	logic signed [ACC_W-1:0] vsum_q;
	logic signed [ACC_W-1:0] ws_q [3];
	logic signed [CB-1:0] lo_q [3];
	logic signed [CB-1:0] hi_q [3];
	logic vseen_q;
	logic [ACC_W-1:0] nq_q, dmag_q, rem_q;
	logic neg_q;
	logic signed [CB-1:0] cen_q [3];

	logic signed [VOL_W-1:0] vol_o_q;
	logic signed [CB-1:0] cen_o_q [3];
	logic signed [CB-1:0] lo_o_q [3];
	logic signed [CB-1:0] hi_o_q [3];
	logic [CB-1:0] long_o_q;
	logic rv_o_q;

	logic signed [CB-1:0] m0a, m0b, m1a, m1b;
	logic signed [2*CB-1:0] p0, p1;
	logic signed [CRW-1:0] cross_v;
	logic signed [CB+CRW-1:0] dprod;
	logic signed [SW-1:0] sum_sel;
	logic signed [PW-1:0] wprod;
	logic signed [ACC_W-1:0] num_sel;
	logic [ACC_W-1:0] rem_sh, qd, qs;
	logic rem_ge;
	logic signed [CB-1:0] lo_v [3];
	logic signed [CB-1:0] hi_v [3];
	logic signed [CB-1:0] mid_v [3];
	logic signed [CB:0] ms [3];
	logic signed [CB:0] ms_adj [3];
	logic [CB:0] ext [3];
	logic [CB:0] longest;
	logic signed [VOL_W-1:0] vol_sat;

	assign pin[0] = a_x;
	assign pin[1] = a_y;
	assign pin[2] = a_z;
	assign stat.vs_zero = (vsum_q == '0);

	always_comb begin
		case (cmd.step)
			2'd1: begin
				m0a = b_q[2]; m0b = c_q[0]; m1a = b_q[0]; m1b = c_q[2];
			end
			2'd2: begin
				m0a = b_q[0]; m0b = c_q[1]; m1a = b_q[1]; m1b = c_q[0];
			end
			default: begin
				m0a = b_q[1]; m0b = c_q[2]; m1a = b_q[2]; m1b = c_q[1];
			end
		endcase
		p0 = m0a * m0b;
		p1 = m1a * m1b;
		cross_v = CRW'(p0) - CRW'(p1);
		dprod = a_q[cmd.step] * cr_q[cmd.step];
		sum_sel = SW'(a_q[cmd.step]) + SW'(b_q[cmd.step]) + SW'(c_q[cmd.step]);
		wprod = sum_sel * d6_q;
		num_sel = ws_q[cmd.step];
		rem_sh = {rem_q[ACC_W-2:0], nq_q[ACC_W-1]};
		rem_ge = (rem_sh >= dmag_q);
		qd = nq_q >> 2;
		if (neg_q)
			qs = (qd > LIM_NEG) ? LIM_NEG : qd;
		else
			qs = (qd > LIM_POS) ? LIM_POS : qd;
	end

	always_comb begin
		longest = '0;
		for (int k = 0; k < 3; k++) begin
			lo_v[k] = vseen_q ? lo_q[k] : '0;
			hi_v[k] = vseen_q ? hi_q[k] : '0;
			ms[k] = (CB+1)'(lo_v[k]) + (CB+1)'(hi_v[k]);
			ms_adj[k] = ms[k] + {{CB{1'b0}}, ms[k][CB]};
			mid_v[k] = CB'(ms_adj[k] >>> 1);
			ext[k] = (CB+1)'(hi_v[k]) - (CB+1)'(lo_v[k]);
			if (ext[k] > longest)
				longest = ext[k];
		end
		if (vsum_q > ACC_W'(VMAX))
			vol_sat = VMAX;
		else if (vsum_q < ACC_W'(VMIN))
			vol_sat = VMIN;
		else
			vol_sat = VOL_W'(vsum_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vsum_q <= '0;
			vseen_q <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				ws_q[k] <= '0;
				lo_q[k] <= CMAX;
				hi_q[k] <= CMIN;
			end
		end else if (cmd.emit) begin
			vsum_q <= '0;
			vseen_q <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				ws_q[k] <= '0;
				lo_q[k] <= CMAX;
				hi_q[k] <= CMIN;
			end
		end else begin
			if (cmd.vtx_upd) begin
				vseen_q <= 1'b1;
				for (int k = 0; k < 3; k++) begin
					if (pin[k] < lo_q[k])
						lo_q[k] <= pin[k];
					if (pin[k] > hi_q[k])
						hi_q[k] <= pin[k];
				end
			end
			if (cmd.wsum_en) begin
				ws_q[cmd.step] <= ws_q[cmd.step] + ACC_W'(wprod);
				if (cmd.step == 2'd0)
					vsum_q <= vsum_q + ACC_W'(d6_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tri_load) begin
			a_q[0] <= a_x; a_q[1] <= a_y; a_q[2] <= a_z;
			b_q[0] <= b_x; b_q[1] <= b_y; b_q[2] <= b_z;
			c_q[0] <= c_x; c_q[1] <= c_y; c_q[2] <= c_z;
		end
		if (cmd.cross_en)
			cr_q[cmd.step] <= cross_v;
		if (cmd.dot_en)
			d6_q <= ((cmd.step == 2'd0) ? DW'(0) : d6_q) + DW'(dprod);
		if (cmd.div_load) begin
			neg_q <= num_sel[ACC_W-1] ^ vsum_q[ACC_W-1];
			nq_q <= num_sel[ACC_W-1] ? -num_sel : num_sel;
			dmag_q <= vsum_q[ACC_W-1] ? -vsum_q : vsum_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_sh - dmag_q : rem_sh;
			nq_q <= {nq_q[ACC_W-2:0], rem_ge};
		end
		if (cmd.div_store)
			cen_q[cmd.step] <= neg_q ? -CB'(qs) : CB'(qs);
		if (cmd.emit) begin
			vol_o_q <= vol_sat;
			long_o_q <= CB'(longest);
			rv_o_q <= !stat.vs_zero && !cmd.ovf;
			for (int k = 0; k < 3; k++) begin
				cen_o_q[k] <= stat.vs_zero ? mid_v[k] : cen_q[k];
				lo_o_q[k] <= lo_v[k];
				hi_o_q[k] <= hi_v[k];
			end
		end
	end

	assign six_volume = vol_o_q;
	assign centroid_x = cen_o_q[0];
	assign centroid_y = cen_o_q[1];
	assign centroid_z = cen_o_q[2];
	assign min_x = lo_o_q[0];
	assign min_y = lo_o_q[1];
	assign min_z = lo_o_q[2];
	assign max_x = hi_o_q[0];
	assign max_y = hi_o_q[1];
	assign max_z = hi_o_q[2];
	assign longest_extent = long_o_q;
	assign result_valid = rv_o_q;
endmodule

// ===== rtl/core/mvcb_ctrl.sv =====
module mvcb_ctrl #(
	parameter int MAX_TRIANGLES = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [1:0]      opcode,
	output logic            out_valid,
	input  logic            out_stall,
	input  mvcb_pkg::stat_t stat,
	output mvcb_pkg::cmd_t  cmd
);
	import mvcb_pkg::*;

	localparam int TCW = $clog2(MAX_TRIANGLES + 1);
	localparam logic [TCW-1:0] TMAX = TCW'(MAX_TRIANGLES);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CROSS  = 3'd1;
	localparam logic [2:0] ST_DOT    = 3'd2;
	localparam logic [2:0] ST_WSUM   = 3'd3;
	localparam logic [2:0] ST_DLOAD  = 3'd4;
	localparam logic [2:0] ST_DSTEP  = 3'd5;
	localparam logic [2:0] ST_DSTORE = 3'd6;
	localparam logic [2:0] ST_EMIT   = 3'd7;

	logic [2:0] state_q;
	logic [1:0] step_q;
	logic [DIV_BITS-1:0] bit_q;
	logic [TCW-1:0] tcnt_q;
	logic ovf_q;
	logic ovalid_q;
	logic accept, tri_ok, emit_ok;

	assign accept = in_valid && (state_q == ST_IDLE);
	assign tri_ok = (tcnt_q < TMAX);
	assign emit_ok = !ovalid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = ovalid_q;

	always_comb begin
		cmd = '0;
		cmd.step = step_q;
		cmd.ovf = ovf_q;
		cmd.vtx_upd = accept && (opcode == OP_VERTEX);
		cmd.tri_load = accept && (opcode == OP_TRIANGLE) && tri_ok;
		cmd.cross_en = (state_q == ST_CROSS);
		cmd.dot_en = (state_q == ST_DOT);
		cmd.wsum_en = (state_q == ST_WSUM);
		cmd.div_load = (state_q == ST_DLOAD);
		cmd.div_step = (state_q == ST_DSTEP);
		cmd.div_store = (state_q == ST_DSTORE);
		cmd.emit = (state_q == ST_EMIT) && emit_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			bit_q <= '0;
			tcnt_q <= '0;
			ovf_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			ovalid_q <= (ovalid_q && out_stall) || cmd.emit;
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (accept && opcode == OP_TRIANGLE) begin
						if (tri_ok) begin
							tcnt_q <= tcnt_q + TCW'(1);
							state_q <= ST_CROSS;
						end else begin
							ovf_q <= 1'b1;
						end
					end else if (accept && opcode == OP_FINISH) begin
						state_q <= stat.vs_zero ? ST_EMIT : ST_DLOAD;
					end
				end
				ST_CROSS, ST_DOT, ST_WSUM: begin
					step_q <= (step_q == 2'd2) ? 2'd0 : step_q + 2'd1;
					if (step_q == 2'd2)
						state_q <= (state_q == ST_WSUM) ? ST_IDLE : state_q + 3'd1;
				end
				ST_DLOAD: begin
					bit_q <= '0;
					state_q <= ST_DSTEP;
				end
				ST_DSTEP: begin
					bit_q <= bit_q + DIV_BITS'(1);
					if (bit_q == DIV_BITS'(ACC_W - 1))
						state_q <= ST_DSTORE;
				end
				ST_DSTORE: begin
					step_q <= (step_q == 2'd2) ? 2'd0 : step_q + 2'd1;
					state_q <= (step_q == 2'd2) ? ST_EMIT : ST_DLOAD;
				end
				ST_EMIT: begin
					if (emit_ok) begin
						tcnt_q <= '0;
						ovf_q <= 1'b0;
						step_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`include "assert_macros.svh"

	`MVCB_ASSERT_IMP(a_emit_free, cmd.emit, !ovalid_q || !out_stall)
	`MVCB_ASSERT_IMP(a_tcnt_bound, 1'b1, tcnt_q <= TMAX)
	`MVCB_ASSERT_NXT(a_finish_busy, accept && opcode == OP_FINISH, ovalid_q || in_stall)
endmodule

// ===== rtl/core/mesh_volume_centroid_bounds_unit.sv =====
// Mesh volume, centroid and bounds unit. Send vertex words to grow the box, triangle
// words (three corners) to accumulate six times the signed volume and the weighted
// corner sums, and a finish word to get one result word and clear everything.
// Vertex words never raise in_stall; a triangle runs three cross-product, three dot-product
// and three weighted-sum steps through shared small multipliers, and a triangle past
// MAX_TRIANGLES is dropped. A finish with a zero volume sum goes straight to the result;
// else the bit-serial 64-bit divider runs once per axis first.
// A result may wait on out_stall; the next finish holds until it is taken.
module mesh_volume_centroid_bounds_unit #(
	parameter int MAX_TRIANGLES = 1024,
	parameter int COORD_BITS    = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    opcode,
	input  logic signed [COORD_BITS-1:0]  a_x,
	input  logic signed [COORD_BITS-1:0]  a_y,
	input  logic signed [COORD_BITS-1:0]  a_z,
	input  logic signed [COORD_BITS-1:0]  b_x,
	input  logic signed [COORD_BITS-1:0]  b_y,
	input  logic signed [COORD_BITS-1:0]  b_z,
	input  logic signed [COORD_BITS-1:0]  c_x,
	input  logic signed [COORD_BITS-1:0]  c_y,
	input  logic signed [COORD_BITS-1:0]  c_z,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [mvcb_pkg::VOL_W-1:0] six_volume,
	output logic signed [COORD_BITS-1:0]  centroid_x,
	output logic signed [COORD_BITS-1:0]  centroid_y,
	output logic signed [COORD_BITS-1:0]  centroid_z,
	output logic signed [COORD_BITS-1:0]  min_x,
	output logic signed [COORD_BITS-1:0]  min_y,
	output logic signed [COORD_BITS-1:0]  min_z,
	output logic signed [COORD_BITS-1:0]  max_x,
	output logic signed [COORD_BITS-1:0]  max_y,
	output logic signed [COORD_BITS-1:0]  max_z,
	output logic [COORD_BITS-1:0]         longest_extent,
	output logic                          result_valid
);
	import mvcb_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	mvcb_ctrl #(.MAX_TRIANGLES(MAX_TRIANGLES)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
		.out_valid(out_valid), .out_stall(out_stall),
		.stat(stat), .cmd(cmd)
	);

	mvcb_datapath #(.COORD_BITS(COORD_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.a_x(a_x), .a_y(a_y), .a_z(a_z),
		.b_x(b_x), .b_y(b_y), .b_z(b_z),
		.c_x(c_x), .c_y(c_y), .c_z(c_z),
		.six_volume(six_volume),
		.centroid_x(centroid_x), .centroid_y(centroid_y), .centroid_z(centroid_z),
		.min_x(min_x), .min_y(min_y), .min_z(min_z),
		.max_x(max_x), .max_y(max_y), .max_z(max_z),
		.longest_extent(longest_extent), .result_valid(result_valid)
	);
endmodule
